// File: design/sfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared constants, types and helper functions for the status frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

  // Frame layout
  localparam int FRAME_LEN            = 45;
  localparam int NEW_PROTOCOL_MIN_LEN = 70;
  localparam int MAX_FRAME_BYTES      = 255;
  localparam int HEX_POS_HIGH         = 76;
  localparam int HEX_POS_LOW          = 77;
  localparam int NUM_FIELDS           = 15;
  localparam int SIGN_FIELD           = 3;
  localparam int FIELD_W              = 14;
  localparam int IDX_W                = 4;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_S     = 8'h73;
  localparam logic [7:0] HEX_LO_OFS = 8'h30;  // '0'
  localparam logic [7:0] HEX_HI_OFS = 8'h57;  // 'a' - 10

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FIELDS - 1);

  // Field start positions and lengths, in frame order
  localparam logic [7:0] FLD_START [NUM_FIELDS] =
    '{8'd1, 8'd4, 8'd7, 8'd10, 8'd11, 8'd14, 8'd17, 8'd19,
      8'd22, 8'd25, 8'd28, 8'd31, 8'd34, 8'd37, 8'd40};
  localparam logic [7:0] FLD_LEN [NUM_FIELDS] =
    '{8'd3, 8'd3, 8'd3, 8'd1, 8'd3, 8'd3, 8'd2, 8'd3,
      8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd4};

  typedef logic [FIELD_W-1:0] field_val_t;

  // One finished frame: check outcome and all field values
  typedef struct packed {
    logic                             ok;
    field_val_t [NUM_FIELDS-1:0]      vals;
  } frame_rec_t;

  // Where a byte position falls in the field map
  typedef struct packed {
    logic             hit;
    logic             first;
    logic [IDX_W-1:0] idx;
  } field_loc_t;

  // Queue status seen by the back end and the input stall
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic field_loc_t locate_field(input logic [7:0] pos);
    field_loc_t r;
    r = '0;
    for (int k = 0; k < NUM_FIELDS; k++) begin
      if ({1'b0, pos} >= {1'b0, FLD_START[k]} &&
          {1'b0, pos} < ({1'b0, FLD_START[k]} + {1'b0, FLD_LEN[k]})) begin
        r.hit   = 1'b1;
        r.first = (pos == FLD_START[k]);
        r.idx   = IDX_W'(k);
      end
    end
    return r;
  endfunction

  // Lower-case hex character of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? (HEX_LO_OFS + {4'h0, nib}) : (HEX_HI_OFS + {4'h0, nib});
  endfunction

endpackage
`default_nettype wire

// File: design/sfp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_front
// Takes frame bytes, keeps count, sum, check bytes and decoded fields, and
// pushes one frame record with its check outcome at frame end.
// ----------------------------------------------------------------------------
module sfp_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              take_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic              frame_end_i,
  output sfp_pkg::frame_rec_t    rec_o,
  output logic                   push_o
);
  import sfp_pkg::*;

  logic [7:0] byte_count_q, byte_count_d;
  logic [7:0] running_sum_q, running_sum_d;
  logic [7:0] first_byte_q, first_byte_d;
  logic [7:0] legacy_chk_q, legacy_chk_d;
  logic [7:0] hex_hi_q, hex_hi_d;
  logic [7:0] hex_lo_q, hex_lo_d;
  field_val_t [NUM_FIELDS-1:0] store_q, store_d;
  logic digit_stopped_q, digit_stopped_d;

  // updated state before the end-of-frame clear
  logic [7:0] cnt_u, sum_u, first_u, legacy_u, hhi_u, hlo_u;
  field_val_t [NUM_FIELDS-1:0] store_u;
  logic stopped_u;

  field_loc_t loc;
  field_val_t base;
  logic       stop;
  logic       is_digit;
  logic       active;
  logic       pass;
  logic       ok;

  assign loc      = locate_field(byte_count_q);
  assign is_digit = (rx_byte_i >= CHAR_ZERO) && (rx_byte_i <= CHAR_NINE);
  assign active   = take_i && (byte_count_q < 8'(MAX_FRAME_BYTES));

  // Byte intake and field decode
  always_comb begin
    cnt_u     = byte_count_q;
    sum_u     = running_sum_q;
    first_u   = first_byte_q;
    legacy_u  = legacy_chk_q;
    hhi_u     = hex_hi_q;
    hlo_u     = hex_lo_q;
    store_u   = store_q;
    stopped_u = digit_stopped_q;
    base      = loc.first ? '0 : store_q[loc.idx];
    stop      = loc.first ? 1'b0 : digit_stopped_q;
    if (active) begin
      if (byte_count_q == 8'd0) first_u = rx_byte_i;
      if (byte_count_q < 8'(FRAME_LEN - 1)) sum_u = running_sum_q + rx_byte_i;
      if (byte_count_q == 8'(FRAME_LEN - 1)) legacy_u = rx_byte_i;
      if (byte_count_q == 8'(HEX_POS_HIGH)) hhi_u = rx_byte_i;
      if (byte_count_q == 8'(HEX_POS_LOW)) hlo_u = rx_byte_i;
      if (loc.hit) begin
        if (loc.idx == IDX_W'(SIGN_FIELD)) begin
          store_u[loc.idx] = FIELD_W'(rx_byte_i);
        end else begin
          store_u[loc.idx] = base;
          stopped_u        = stop;
          if (!stop && is_digit) begin
            // times ten by shift and add
            store_u[loc.idx] = (base << 3) + (base << 1) +
                               FIELD_W'(rx_byte_i - CHAR_ZERO);
          end else begin
            stopped_u = 1'b1;
          end
        end
      end
      cnt_u = byte_count_q + 8'd1;
    end
  end

  // Frame check on the updated state
  always_comb begin
    if (cnt_u > 8'(NEW_PROTOCOL_MIN_LEN)) begin
      pass = (hhi_u == hex_char(sum_u[7:4])) && (hlo_u == hex_char(sum_u[3:0]));
    end else begin
      pass = (legacy_u == sum_u);
    end
    ok = pass || (first_u == CHAR_S);
  end

  assign push_o   = take_i && frame_end_i;
  assign rec_o.ok = ok;
  assign rec_o.vals = ok ? store_u : '0;

  // Clear everything once the frame is handed off
  always_comb begin
    byte_count_d    = cnt_u;
    running_sum_d   = sum_u;
    first_byte_d    = first_u;
    legacy_chk_d    = legacy_u;
    hex_hi_d        = hhi_u;
    hex_lo_d        = hlo_u;
    store_d         = store_u;
    digit_stopped_d = stopped_u;
    if (push_o) begin
      byte_count_d    = '0;
      running_sum_d   = '0;
      first_byte_d    = '0;
      legacy_chk_d    = '0;
      hex_hi_d        = '0;
      hex_lo_d        = '0;
      store_d         = '0;
      digit_stopped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q    <= '0;
      running_sum_q   <= '0;
      first_byte_q    <= '0;
      legacy_chk_q    <= '0;
      hex_hi_q        <= '0;
      hex_lo_q        <= '0;
      store_q         <= '0;
      digit_stopped_q <= 1'b0;
    end else begin
      byte_count_q    <= byte_count_d;
      running_sum_q   <= running_sum_d;
      first_byte_q    <= first_byte_d;
      legacy_chk_q    <= legacy_chk_d;
      hex_hi_q        <= hex_hi_d;
      hex_lo_q        <= hex_lo_d;
      store_q         <= store_d;
      digit_stopped_q <= digit_stopped_d;
    end
  end

endmodule
`default_nettype wire

// File: design/sfp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_queue
// Two-entry queue of finished frame records between front and back ends.
// ----------------------------------------------------------------------------
module sfp_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire sfp_pkg::frame_rec_t  push_rec_i,
  input  wire logic                 pop_i,
  output sfp_pkg::frame_rec_t       head_rec_o,
  output sfp_pkg::q_status_t        status_o
);
  import sfp_pkg::*;

  frame_rec_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);
  assign head_rec_o     = entry_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule
`default_nettype wire

// File: design/sfp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_back
// Walks the head frame record and hands out its fifteen field words.
// ----------------------------------------------------------------------------
module sfp_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire sfp_pkg::frame_rec_t        head_rec_i,
  input  wire sfp_pkg::q_status_t         q_status_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [sfp_pkg::IDX_W-1:0]       field_index_o,
  output logic [sfp_pkg::FIELD_W-1:0]     field_value_o,
  output logic                            frame_ok_o,
  output logic                            last_field_o
);
  import sfp_pkg::*;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             send;

  assign out_valid_o   = !q_status_i.empty;
  assign send          = out_valid_o && !out_stall_i;
  assign last_field_o  = (idx_q == LAST_IDX);
  assign pop_o         = send && last_field_o;
  assign field_index_o = idx_q;
  assign field_value_o = head_rec_i.vals[idx_q];
  assign frame_ok_o    = head_rec_i.ok;

  // Field counter
  always_comb begin
    idx_d = idx_q;
    if (send) begin
      idx_d = last_field_o ? '0 : idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
`default_nettype wire

// File: design/status_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// status_frame_parser
// Status frame parser: byte intake, frame check and field result stream.
// ----------------------------------------------------------------------------
// Takes one frame byte per clock while not stalled. At the byte marked
// frame_end the frame is checked and its record goes into a two-entry queue;
// the output side then delivers fifteen field words, one per cycle when not
// stalled. Input is stalled only while both queue entries hold frames not
// yet fully read out. Values are zero when a frame is rejected.
// ----------------------------------------------------------------------------
module status_frame_parser (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [7:0]                 rx_byte_i,
  input  wire logic                       frame_end_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [sfp_pkg::IDX_W-1:0]       field_index_o,
  output logic [sfp_pkg::FIELD_W-1:0]     field_value_o,
  output logic                            frame_ok_o,
  output logic                            last_field_o
);
  import sfp_pkg::*;

  frame_rec_t push_rec;
  frame_rec_t head_rec;
  q_status_t  q_status;
  logic       push;
  logic       pop;
  logic       take;

  assign in_stall_o = q_status.full;
  assign take       = in_valid_i && !in_stall_o;

  sfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .rx_byte_i   (rx_byte_i),
    .frame_end_i (frame_end_i),
    .rec_o       (push_rec),
    .push_o      (push)
  );

  sfp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .head_rec_o (head_rec),
    .status_o   (q_status)
  );

  sfp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_rec_i    (head_rec),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .field_index_o (field_index_o),
    .field_value_o (field_value_o),
    .frame_ok_o    (frame_ok_o),
    .last_field_o  (last_field_o)
  );

endmodule
`default_nettype wire

// File: design/sfp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_checker
// Port-level checks on the field word stream of the status frame parser.
// ----------------------------------------------------------------------------
module sfp_checker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       out_valid_o,
  input  wire logic                       out_stall_i,
  input  wire logic [sfp_pkg::IDX_W-1:0]  field_index_o,
  input  wire logic [sfp_pkg::FIELD_W-1:0] field_value_o,
  input  wire logic                       frame_ok_o,
  input  wire logic                       last_field_o
);
  import sfp_pkg::*;

  // Last flag only on the final field
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_field_o == (field_index_o == LAST_IDX)))
    else $error("last_field does not match field index");

  // Rejected frames carry zero values
  a_rej_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_ok_o) |-> (field_value_o == '0))
    else $error("rejected frame with nonzero value");

  // Fields of a frame follow back to back in order with one verdict
  a_next_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_field_o) |=>
      (out_valid_o && field_index_o == $past(field_index_o) + IDX_W'(1) &&
       frame_ok_o == $past(frame_ok_o)))
    else $error("field sequence broken within a frame");

  // Stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(field_index_o) && $stable(field_value_o)))
    else $error("stalled word changed");

endmodule

bind status_frame_parser sfp_checker u_sfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .field_index_o (field_index_o),
  .field_value_o (field_value_o),
  .frame_ok_o    (frame_ok_o),
  .last_field_o  (last_field_o)
);
`default_nettype wire
